>>> src/pdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_pkg
// types and constants shared by the packet deframer modules
// ----------------------------------------------------------------------------
package pdt_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned KIND_W  = 2;

    // input item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // frame parser phases
    localparam logic [PHASE_W-1:0] PH_SRC  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DST  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CMD  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] EV_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] EV_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] EV_ABORT   = 2'd2;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [BYTE_W-1:0] src_addr;
        logic [BYTE_W-1:0] dst_addr;
        logic [BYTE_W-1:0] cmd_code;
        logic [BYTE_W-1:0] payload_len;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
    } result_t;

endpackage

>>> src/pdt_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_parser
// frame header / payload parser with idle tick counter and timeout abort
// ----------------------------------------------------------------------------
module pdt_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_op,
    input  logic [pdt_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          cfg_we,
    input  logic [pdt_pkg::TICK_W-1:0]    cfg_data,
    output logic                          res_valid,
    output pdt_pkg::result_t              res
);
    import pdt_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  src_reg, src_next;
    logic [BYTE_W-1:0]  dst_reg, dst_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0]  count_reg, count_next;
    logic [TICK_W-1:0]  idle_reg, idle_next;
    logic [TICK_W-1:0]  limit_reg;
    logic [TICK_W-1:0]  idle_inc;
    logic [BYTE_W:0]    count_plus;
    logic               is_last;

    assign idle_inc   = (idle_reg == TICK_MAX) ? idle_reg : idle_reg + 16'd1;
    assign count_plus = {1'b0, count_reg} + 9'd1;
    assign is_last    = count_plus >= {1'b0, len_reg};

    always_comb
    begin
        phase_next = phase_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        idle_next  = idle_reg;
        res_valid  = 1'b0;
        res        = '{event_kind: EV_PAYLOAD, src_addr: src_reg, dst_addr: dst_reg,
                       cmd_code: cmd_reg, payload_len: len_reg, byte_index: '0,
                       payload_byte: '0, frame_last: 1'b0};
        if (in_valid)
        begin
            if (in_op == OP_TICK)
            begin
                idle_next = idle_inc;
                if (idle_inc > limit_reg && phase_reg != PH_SRC)
                begin
                    res_valid      = 1'b1;
                    res.event_kind = EV_ABORT;
                    phase_next     = PH_SRC;
                    count_next     = '0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_DST:
                    begin
                        dst_next   = in_byte;
                        phase_next = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        cmd_next   = in_byte;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        len_next = in_byte;
                        if (in_byte == '0)
                        begin
                            res_valid           = 1'b1;
                            res.event_kind      = EV_EMPTY;
                            res.payload_len     = in_byte;
                            res.frame_last      = 1'b1;
                            count_next          = '0;
                            phase_next          = PH_SRC;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        res_valid        = 1'b1;
                        res.byte_index   = count_reg;
                        res.payload_byte = in_byte;
                        res.frame_last   = is_last;
                        if (is_last)
                        begin
                            count_next = '0;
                            phase_next = PH_SRC;
                        end
                        else
                        begin
                            count_next = count_plus[BYTE_W-1:0];
                        end
                    end
                    default:
                    begin
                        // awaiting source byte: frame start restarts the idle count
                        src_next   = in_byte;
                        idle_next  = '0;
                        phase_next = PH_DST;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SRC;
            src_reg   <= '0;
            dst_reg   <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            idle_reg  <= '0;
            limit_reg <= TIMEOUT_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            idle_reg  <= idle_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SRC || phase_reg == PH_DST || phase_reg == PH_CMD ||
        phase_reg == PH_LEN || phase_reg == PH_DATA)
        else $error("parser phase out of range");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_DATA |-> count_reg == '0)
        else $error("payload count not cleared outside payload phase");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> count_reg < len_reg)
        else $error("payload count beyond declared length");

    a_abort_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_kind == EV_ABORT) |=> phase_reg == PH_SRC)
        else $error("abort did not return parser to frame start");
`endif

endmodule

>>> src/pdt_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_out_buf
// output register with skid stage, keeps the input side free of m_tready
// ----------------------------------------------------------------------------
module pdt_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pdt_pkg::result_t     push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pdt_pkg::result_t     out_data
);
    import pdt_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held with empty output register");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result pushed into full buffer");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> !skid_valid_reg && out_valid_reg)
        else $error("skid beat lost on pop");
`endif

endmodule

>>> src/packet_deframer_with_timeout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_deframer_with_timeout
// length-prefixed frame parser for received uart bytes with idle timeout
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one beat per received byte (s_tuser = 0, byte in s_tdata)
//   or per time tick (s_tuser = 1, s_tdata ignored)
//   frames are source, target, command, length, then length payload bytes
//   m_* gives at most one beat per input beat: a payload byte with its
//   header and index, an empty-frame completion, or a timeout abort
//   cfg_* writes the 16-bit timeout limit (ticks after frame start); the user
//   must write it only while the block is idle, not enforced by the block;
//   cfg_ready is always high; m_* results come from the output register
// throughput: one input beat per cycle while s_tready is high, set by the
// single parse stage feeding a two-entry output register / skid stage
// while m_tready holds a result back, the next result fills the skid stage
// and s_tready drops right after that beat, staying low until a beat drains
// reset: parser waits for a source byte, header registers and idle count
// are zero, timeout limit is 100, output buffer is empty
// ----------------------------------------------------------------------------
module packet_deframer_with_timeout
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // src_addr, dst_addr, cmd_code, payload_len,
                                   // byte_index, payload_byte
    output logic [1:0]  m_tuser,   // event_kind
    output logic        m_tlast,   // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import pdt_pkg::*;

    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    buf_ready;

    assign s_tready  = buf_ready;
    assign in_accept = s_tvalid && buf_ready;
    assign cfg_ready = 1'b1;

    pdt_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    pdt_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_push  (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.payload_byte, out_res.byte_index, out_res.payload_len,
                      out_res.cmd_code, out_res.dst_addr, out_res.src_addr};
    assign m_tuser = out_res.event_kind;
    assign m_tlast = out_res.frame_last;

endmodule

>>> bench/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// watches the deframer's byte, result and limit channels, keeps its own copy
// of the frame parser and compares every result beat with the oldest
// prediction
// ----------------------------------------------------------------------------
module deframer_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          payload_seen,
    output int          empty_seen,
    output int          abort_seen
);
    import pdt_pkg::*;

    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  hdr_src;
    logic [BYTE_W-1:0]  hdr_dst;
    logic [BYTE_W-1:0]  hdr_cmd;
    logic [BYTE_W-1:0]  hdr_len;
    logic [BYTE_W-1:0]  data_count;
    logic [TICK_W-1:0]  idle_count;
    logic [TICK_W-1:0]  limit;
    result_t            frames_due[$];
    result_t            oldest;

    function automatic result_t frame_result(input logic [KIND_W-1:0] kind,
                                             input logic [BYTE_W-1:0] idx,
                                             input logic [BYTE_W-1:0] data,
                                             input logic last);
        result_t r;
        r.event_kind   = kind;
        r.src_addr     = hdr_src;
        r.dst_addr     = hdr_dst;
        r.cmd_code     = hdr_cmd;
        r.payload_len  = hdr_len;
        r.byte_index   = idx;
        r.payload_byte = data;
        r.frame_last   = last;
        return r;
    endfunction

    task automatic parse_beat(input logic op, input logic [BYTE_W-1:0] b);
        logic [PHASE_W-1:0] ph;
        logic               last;
        ph = (phase > PH_DATA) ? PH_SRC : phase;
        if (op == OP_TICK)
        begin
            if (idle_count != TICK_MAX)
                idle_count = idle_count + 1'b1;
            // an idle parser only counts, a partial frame is dropped
            if (idle_count > limit && ph != PH_SRC)
            begin
                frames_due.push_back(frame_result(EV_ABORT, '0, '0, 1'b0));
                phase      = PH_SRC;
                data_count = '0;
            end
            else
                phase = ph;
        end
        else
        begin
            case (ph)
                PH_SRC:
                begin
                    hdr_src    = b;
                    idle_count = '0;
                    phase      = PH_DST;
                end
                PH_DST:
                begin
                    hdr_dst = b;
                    phase   = PH_CMD;
                end
                PH_CMD:
                begin
                    hdr_cmd = b;
                    phase   = PH_LEN;
                end
                PH_LEN:
                begin
                    hdr_len = b;
                    if (b == '0)
                    begin
                        data_count = '0;
                        phase      = PH_SRC;
                        frames_due.push_back(frame_result(EV_EMPTY, '0, '0, 1'b1));
                    end
                    else
                        phase = PH_DATA;
                end
                default:
                begin
                    last = ({1'b0, data_count} + 9'd1) >= {1'b0, hdr_len};
                    frames_due.push_back(frame_result(EV_PAYLOAD, data_count, b, last));
                    if (last)
                    begin
                        data_count = '0;
                        phase      = PH_SRC;
                    end
                    else
                    begin
                        data_count = data_count + 1'b1;
                        phase      = PH_DATA;
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase        = PH_SRC;
            hdr_src      = '0;
            hdr_dst      = '0;
            hdr_cmd      = '0;
            hdr_len      = '0;
            data_count   = '0;
            idle_count   = '0;
            limit        = TIMEOUT_RESET;
            frames_due.delete();
            fail_count   = 0;
            pending      = 0;
            payload_seen = 0;
            empty_seen   = 0;
            abort_seen   = 0;
        end
        else
        begin
            // results are registered before they leave, so retire first
            if (m_tvalid && m_tready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    oldest = frames_due.pop_front();
                    check_field("event_kind", oldest.event_kind, m_tuser);
                    check_field("src_addr", oldest.src_addr, m_tdata[7:0]);
                    check_field("dst_addr", oldest.dst_addr, m_tdata[15:8]);
                    check_field("cmd_code", oldest.cmd_code, m_tdata[23:16]);
                    check_field("payload_len", oldest.payload_len, m_tdata[31:24]);
                    check_field("byte_index", oldest.byte_index, m_tdata[39:32]);
                    check_field("payload_byte", oldest.payload_byte, m_tdata[47:40]);
                    check_field("frame_last", oldest.frame_last, m_tlast);
                    case (oldest.event_kind)
                        EV_PAYLOAD: payload_seen++;
                        EV_EMPTY:   empty_seen++;
                        default:    abort_seen++;
                    endcase
                end
            end
            if (cfg_valid && cfg_ready)
                limit = cfg_data;
            if (s_tvalid && s_tready)
                parse_beat(s_tuser, s_tdata);
            pending = frames_due.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives bytes and ticks into the packet deframer, with directed frames,
// timeouts at the limit extremes and random traffic under several timeout
// limits; results are checked by deframer_checker
// ----------------------------------------------------------------------------
module testbench;
    import pdt_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending;
    int          payload_seen;
    int          empty_seen;
    int          abort_seen;

    int          cycles;
    int          beats_sent;
    int          settings_used;
    int unsigned timeout_now;
    bit          calm;

    packet_deframer_with_timeout dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    deframer_checker deframe_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .payload_seen (payload_seen),
        .empty_seen   (empty_seen),
        .abort_seen   (abort_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("packet_deframer_with_timeout: mismatch");
            $finish;
        end
    end

    // result side: ready runs with stall bursts, steady ready at the end
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            if (calm)
                @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 20)) @(posedge clk);
                if ($urandom_range(0, 1) == 1)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // hold off input until every predicted result has left the block
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        timeout_now  = value;
        settings_used++;
    endtask

    task automatic send_frame(input int unsigned len, input bit truncate,
                              input bit with_ticks);
        logic [7:0]  hdr[4];
        int unsigned stop;
        hdr[0] = 8'($urandom);
        hdr[1] = 8'($urandom);
        hdr[2] = 8'($urandom);
        hdr[3] = 8'(len);
        stop   = truncate ? $urandom_range(1, 3 + len) : 4 + len;
        for (int unsigned k = 0; k < stop; k++)
        begin
            if (with_ticks && $urandom_range(0, 99) < 8)
                send_item(OP_TICK, 8'($urandom));
            send_item(OP_BYTE, (k < 4) ? hdr[k] : 8'($urandom));
        end
        // a cut-short frame is followed by enough ticks to drop it when the limit is at most 40
        if (truncate)
            repeat ((timeout_now <= 40) ? timeout_now + 1 : 3)
                send_item(OP_TICK, 8'($urandom));
    endtask

    task automatic random_phase(input int beats, input bit long_first);
        int          start;
        int unsigned pick;
        int unsigned len;
        start = beats_sent;
        if (long_first)
            send_frame(255, 1'b0, 1'b0);
        while (beats_sent - start < beats)
        begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(0, 19);
            len  = (len < 14) ? $urandom_range(0, 6) :
                   (len < 19) ? $urandom_range(7, 40) : $urandom_range(41, 255);
            if (pick < 75)
                send_frame(len, 1'b0, 1'b1);
            else if (pick < 87)
                send_frame(len, 1'b1, 1'b1);
            else
                send_item(1'($urandom_range(0, 1)), 8'($urandom));
        end
    endtask

    initial
    begin
        logic [15:0] limits[8];
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_BYTE;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        cycles        = 0;
        beats_sent    = 0;
        settings_used = 0;
        timeout_now   = TIMEOUT_RESET;
        calm          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset limit
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hA5);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h5A);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_BYTE, 8'hAA);
        send_item(OP_BYTE, 8'h0F);
        send_item(OP_BYTE, 8'h02);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h80);

        // partial header dropped on the third tick, then ticks while idle
        write_limit(16'd2);
        send_item(OP_BYTE, 8'h12);
        send_item(OP_BYTE, 8'h34);
        repeat (3) send_item(OP_TICK, 8'h00);
        repeat (3) send_item(OP_TICK, 8'hFF);

        // zero limit drops a frame on its first tick
        write_limit(16'd0);
        send_item(OP_BYTE, 8'h77);
        send_item(OP_TICK, 8'h00);

        // full limit never fires on a partial frame
        write_limit(16'hFFFF);
        send_item(OP_BYTE, 8'h3C);
        repeat (40) send_item(OP_TICK, 8'($urandom));
        send_item(OP_BYTE, 8'hC3);
        write_limit(TIMEOUT_RESET);
        send_item(OP_TICK, 8'h00);

        limits = '{16'd1, 16'd2, 16'd0, 16'($urandom_range(3, 30)),
                   16'hFFFE, 16'd3, 16'hFFFF, TIMEOUT_RESET};
        for (int p = 0; p < 8; p++)
        begin
            write_limit(limits[p]);
            calm = (p == 7);
            random_phase(70, p == 4);
        end

        drain();
        $display("%0d input beats under %0d timeout settings, incl. the extreme limits",
                 beats_sent, settings_used);
        $display("results checked: %0d payload, %0d empty frame, %0d timeout abort",
                 payload_seen, empty_seen, abort_seen);
        if (fail_count == 0)
            $display("packet_deframer_with_timeout: match");
        else
            $display("packet_deframer_with_timeout: mismatch");
        $finish;
    end

endmodule
